// ----- design/cdq_pkg.sv -----
package cdq_pkg;

  // ring geometry
  localparam int DEPTH = 8;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // operation codes
  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_REAR  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_REAR   = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } stat_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

endpackage

// ----- design/cdq_if.sv -----
interface cdq_req_if;
  import cdq_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink (input valid, input func, input push_value, output ready);
endinterface

interface cdq_rsp_if;
  import cdq_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] popped_value;
  logic [CNT_W-1:0]   count;

  modport source (output valid, output status, output popped_value, output count,
                  input ready);
  modport sink (input valid, input status, input popped_value, input count,
                output ready);
endinterface

// ----- design/cdq_ctrl.sv -----
module cdq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  cdq_pkg::stat_t stat,
  output cdq_pkg::cmd_t  cmd
);
  import cdq_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic   ready;

  assign req_ready   = ready;
  assign cmd.capture = ready && req_valid;
  assign cmd.execute = (state == ST_EXEC) && stat.out_free;

  // state and registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ready <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ready && req_valid) begin
            state <= ST_EXEC;
            ready <= 1'b0;
          end else begin
            ready <= 1'b1;
          end
        end
        ST_EXEC: begin
          if (stat.out_free) begin
            state <= ST_IDLE;
            ready <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
          ready <= 1'b0;
        end
      endcase
    end
  end

  // ready only while idle
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    ready |-> (state == ST_IDLE))
    else $error("ready raised outside idle");

  // capture and execute never overlap
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.execute))
    else $error("capture and execute in the same cycle");

  // an accepted item is executed before the next one is taken
  a_no_double: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !ready)
    else $error("ready high right after a transfer");

endmodule

// ----- design/cdq_dp.sv -----
module cdq_dp (
  input  logic          clk,
  input  logic          rst,
  input  cdq_pkg::cmd_t cmd,
  output cdq_pkg::stat_t stat,
  cdq_req_if.sink       req,
  cdq_rsp_if.source     rsp
);
  import cdq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [1:0]        op;
  logic [DATA_W-1:0] val;

  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [CNT_W-1:0]  held_count;

  logic [PTR_W-1:0]  head_next;
  logic [PTR_W-1:0]  tail_next;
  logic [CNT_W-1:0]  held_count_next;
  logic [1:0]        status_next;
  logic [DATA_W-1:0] popped_next;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic              is_empty;
  logic              is_pop;

  logic              out_valid;
  logic [1:0]        out_status;
  logic [DATA_W-1:0] out_popped;
  logic [CNT_W-1:0]  out_count;

  assign is_empty      = (held_count == '0);
  assign is_pop        = (op == FUNC_POP_FRONT) || (op == FUNC_POP_REAR);
  assign stat.out_free = !out_valid || rsp.ready;

  // capture the request and read the end slot a pop would take
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op      <= req.func;
      val     <= req.push_value;
      rd_data <= mem[(req.func == FUNC_POP_FRONT) ? head : tail];
    end
    if (wr_en) begin
      mem[wr_addr] <= val;
    end
  end

  // operation result and next pointers
  always_comb begin
    head_next       = head;
    tail_next       = tail;
    held_count_next = held_count;
    status_next     = STATUS_DONE;
    popped_next     = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    case (op)
      FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
        if (held_count == CNT_FULL) begin
          status_next = STATUS_FULL;
        end else begin
          wr_en           = cmd.execute;
          held_count_next = held_count + 1'b1;
          if (is_empty) begin
            head_next = '0;
            tail_next = '0;
            wr_addr   = '0;
          end else if (op == FUNC_PUSH_FRONT) begin
            head_next = ptr_prev(head);
            wr_addr   = head_next;
          end else begin
            tail_next = ptr_next(tail);
            wr_addr   = tail_next;
          end
        end
      end
      FUNC_POP_FRONT, FUNC_POP_REAR: begin
        if (is_empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          popped_next     = rd_data;
          held_count_next = held_count - 1'b1;
          if (held_count > CNT_W'(1)) begin
            if (op == FUNC_POP_FRONT) begin
              head_next = ptr_next(head);
            end else begin
              tail_next = ptr_prev(tail);
            end
          end
        end
      end
      default: begin
        status_next = STATUS_DONE;
      end
    endcase
  end

  // deque state
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      held_count <= '0;
    end else if (cmd.execute) begin
      head       <= head_next;
      tail       <= tail_next;
      held_count <= held_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_status <= status_next;
      out_popped <= popped_next;
      out_count  <= held_count_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.popped_value = out_popped;
  assign rsp.count        = out_count;

  // count never exceeds the ring size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_FULL)
    else $error("held count beyond depth");

  // a result is only loaded into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |-> (!rsp.valid || rsp.ready))
    else $error("result overwrote a pending transfer");

  // refused operations leave the count alone
  a_refused: assert property (@(posedge clk) disable iff (rst)
    (cmd.execute && (status_next != STATUS_DONE)) |=> (held_count == $past(held_count)))
    else $error("refused operation changed count");

  // a successful pop removes exactly one element
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.execute && is_pop && !is_empty) |=>
      (held_count == CNT_W'($past(held_count) - 1'b1)))
    else $error("pop did not drop count by one");

endmodule

// ----- design/circular_deque.sv -----
// channel  dir  handshake          payload
// req      in   valid / ready      func[1:0], push_value[31:0]
// rsp      out  valid / ready      status[1:0], popped_value[31:0], count[3:0]
//
// each operation runs in two steps: a transfer on req captures it and reads
// the end slot of the ring, then ST_EXEC updates pointers and loads rsp
// a new req transfer is taken while an earlier result still waits on rsp;
// execution stalls only while that result register is still occupied
// rst is synchronous; head, tail and count clear, ring contents stay unknown
module circular_deque (
  input logic       clk,
  input logic       rst,
  cdq_req_if.sink   req,
  cdq_rsp_if.source rsp
);
  import cdq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cdq_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );

endmodule
